@@ hdl/vpa_pkg.sv @@
`default_nettype none
package vpa_pkg;
  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_RELEASE = 2'd1,
    KIND_REINIT  = 2'd2,
    KIND_NOP     = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    FIT_FIRST = 2'd0,
    FIT_BEST  = 2'd1,
    FIT_WORST = 2'd2,
    FIT_BAD   = 2'd3
  } fit_t;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NO_FIT  = 3'd1,
    ST_BAD_POL = 3'd2,
    ST_FULL    = 3'd3,
    ST_BAD_IDX = 3'd4
  } status_t;

  localparam logic [15:0] RESET_SIZE = 16'd100;
endpackage
`default_nettype wire

@@ hdl/vpa_ram.sv @@
`default_nettype none
module vpa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ hdl/variable_partition_allocator.sv @@
`default_nettype none
// Variable-partition allocator. A request steps through a state machine: the free table
// (USED_SLOTS+1 segments, in registers) is scanned one entry per cycle with one
// shared length comparator, then shifted one entry per cycle on insert or
// remove; the allocated stack lives in a RAM that is shifted one word per
// read state and write state pair (S_USH_RD/S_USH_WR, S_UDN_RD/S_UDN_WR).
// Results wait in an output register; tready on the input is high only idle.
module variable_partition_allocator
  import vpa_pkg::*;
#(
  parameter int USED_SLOTS = 16,
  parameter int ADDR_BITS  = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [15:0] cfg_wdata,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // kind[1:0], request_size[17:2], fit_policy[19:18], release_index[23:20]
  input  wire logic [23:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // status[2:0], block_start[18:3], block_length[34:19],
  // running_count[39:35], free_segments[44:40], zero fill
  output logic [47:0]      m_tdata
);
  localparam int FS  = USED_SLOTS + 1;
  localparam int FIW = $clog2(FS + 1);
  localparam int UIW = $clog2(USED_SLOTS);
  localparam int UCW = $clog2(USED_SLOTS + 1);
  localparam int AW  = ADDR_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_SCAN, S_CARVE, S_FDROP, S_USH_RD, S_USH_WR,
    S_REL_RD, S_REL_WAIT, S_UDN_RD, S_UDN_WR, S_FIND, S_MERGE, S_FINS, S_OUT
  } state_t;

  state_t state;
  logic [15:0]  memory_size;
  logic [AW-1:0] fstart [FS];
  logic [AW-1:0] flen   [FS];
  logic [FIW-1:0] fcount;
  logic [UCW-1:0] ucount;

  logic [1:0]  kind;
  logic [15:0] rsize;
  logic [1:0]  pol;
  logic [3:0]  ridx;
  logic [FIW-1:0] i;
  logic [FIW-1:0] sel;
  logic        sel_ok;
  logic [UCW-1:0] k;
  logic [AW-1:0] bs, bl;
  logic [2:0]  status;
  logic [47:0] obuf;

  // used-stack RAM, start and length packed
  logic           u_we;
  logic [UIW-1:0] u_waddr, u_raddr;
  logic [2*AW-1:0] u_wdata, u_rdata;

  vpa_ram #(.WIDTH(2 * AW), .DEPTH(USED_SLOTS)) u_used (
    .clk(clk), .we(u_we), .waddr(u_waddr), .wdata(u_wdata),
    .raddr(u_raddr), .rdata(u_rdata)
  );

  // shared comparator against the scanned free entry
  logic [FIW-1:0] ic;
  logic [AW-1:0]  cur_len, sel_len;
  logic           fits, better;
  always_comb begin
    ic = (i < FIW'(FS)) ? i : '0;
    cur_len = flen[ic[$clog2(FS)-1:0]];
    sel_len = flen[sel[$clog2(FS)-1:0]];
    fits = (rsize != 16'd0) && ({16'd0, cur_len} >= {{AW{1'b0}}, rsize});
    better = !sel_ok || (pol == FIT_BEST && cur_len < sel_len) ||
             (pol == FIT_WORST && cur_len > sel_len);
  end

  logic [$clog2(FS)-1:0] si, sp;
  logic [AW:0] left_end, right_end;
  logic left_m, right_m;
  always_comb begin
    si = sel[$clog2(FS)-1:0];
    sp = (sel == '0) ? '0 : $clog2(FS)'(sel - 1'b1);
    left_end  = {1'b0, fstart[sp]} + {1'b0, flen[sp]};
    right_end = {1'b0, bs} + {1'b0, bl};
    left_m  = (sel != '0) && (left_end == {1'b0, bs});
    right_m = (sel < fcount) && (right_end == {1'b0, fstart[si]});
  end

  assign s_tready = (state == S_IDLE);
  assign m_tdata  = obuf;

  always_comb begin
    u_we = 1'b0;
    u_waddr = k[UIW-1:0];
    u_wdata = u_rdata;
    u_raddr = k[UIW-1:0];
    case (state)
      S_USH_RD: u_raddr = UIW'(k - 1'b1);
      S_USH_WR: begin
        u_we = 1'b1;
        u_waddr = k[UIW-1:0];
        u_wdata = (k == '0) ? {bl, bs} : u_rdata;
      end
      S_REL_RD: u_raddr = UIW'(ridx);
      S_UDN_RD: u_raddr = UIW'(k + 1'b1);
      S_UDN_WR: begin
        u_we = 1'b1;
        u_waddr = k[UIW-1:0];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      m_tvalid <= 1'b0;
      memory_size <= RESET_SIZE;
      fcount <= FIW'(1);
      ucount <= '0;
      fstart[0] <= AW'(1);
      flen[0] <= AW'(RESET_SIZE);
    end else begin
      if (cfg_we) memory_size <= cfg_wdata;
      if (m_tvalid && m_tready && state != S_OUT) m_tvalid <= 1'b0;
      case (state)
        S_IDLE: if (s_tvalid) begin
          kind <= s_tdata[1:0];
          rsize <= s_tdata[17:2];
          pol <= s_tdata[19:18];
          ridx <= s_tdata[23:20];
          i <= '0;
          sel <= '0;
          sel_ok <= 1'b0;
          bs <= '0;
          bl <= '0;
          status <= ST_OK;
          case (kind_t'(s_tdata[1:0]))
            KIND_ALLOC: begin
              if (s_tdata[19:18] == FIT_BAD) begin
                status <= ST_BAD_POL;
                state <= S_OUT;
              end else if (ucount >= UCW'(USED_SLOTS)) begin
                status <= ST_FULL;
                state <= S_OUT;
              end else state <= S_SCAN;
            end
            KIND_RELEASE: begin
              if (32'(s_tdata[23:20]) >= 32'(ucount)) begin
                status <= ST_BAD_IDX;
                state <= S_OUT;
              end else state <= S_REL_RD;
            end
            KIND_REINIT: begin
              ucount <= '0;
              fcount <= (memory_size != 16'd0) ? FIW'(1) : '0;
              fstart[0] <= AW'(1);
              flen[0] <= AW'(memory_size);
              bs <= AW'(1);
              bl <= AW'(memory_size);
              state <= S_OUT;
            end
            default: state <= S_OUT;
          endcase
        end
        S_SCAN: begin
          if (i >= fcount || (pol == FIT_FIRST && sel_ok)) begin
            if (!sel_ok) begin
              status <= ST_NO_FIT;
              state <= S_OUT;
            end else begin
              bs <= fstart[si];
              bl <= AW'(rsize);
              state <= S_CARVE;
            end
          end else begin
            if (fits && better) begin
              sel <= i;
              sel_ok <= 1'b1;
            end
            i <= i + 1'b1;
          end
        end
        S_CARVE: begin
          fstart[si] <= fstart[si] + AW'(rsize);
          flen[si] <= flen[si] - AW'(rsize);
          i <= sel;
          k <= ucount;
          state <= (flen[si] == AW'(rsize)) ? S_FDROP : S_USH_RD;
        end
        S_FDROP: begin
          // close the gap one entry per cycle
          if (i + 1'b1 < fcount) begin
            fstart[ic[$clog2(FS)-1:0]] <= fstart[$clog2(FS)'(ic + 1'b1)];
            flen[ic[$clog2(FS)-1:0]] <= flen[$clog2(FS)'(ic + 1'b1)];
            i <= i + 1'b1;
          end else begin
            fcount <= fcount - 1'b1;
            state <= (kind == KIND_ALLOC) ? S_USH_RD : S_OUT;
          end
        end
        S_USH_RD: state <= S_USH_WR;
        S_USH_WR: begin
          if (k == '0) begin
            ucount <= ucount + 1'b1;
            state <= S_OUT;
          end else begin
            k <= k - 1'b1;
            state <= S_USH_RD;
          end
        end
        S_REL_RD: state <= S_REL_WAIT;
        S_REL_WAIT: begin
          bs <= u_rdata[AW-1:0];
          bl <= u_rdata[2*AW-1:AW];
          k <= UCW'(ridx);
          state <= S_UDN_RD;
        end
        S_UDN_RD: begin
          if (k + 1'b1 >= ucount) begin
            ucount <= ucount - 1'b1;
            sel <= '0;
            state <= S_FIND;
          end else state <= S_UDN_WR;
        end
        S_UDN_WR: begin
          k <= k + 1'b1;
          state <= S_UDN_RD;
        end
        S_FIND: begin
          if (sel < fcount && fstart[si] < bs) sel <= sel + 1'b1;
          else state <= S_MERGE;
        end
        S_MERGE: begin
          if (left_m && right_m) begin
            flen[sp] <= flen[sp] + bl + flen[si];
            i <= sel;
            state <= S_FDROP;
          end else if (left_m) begin
            flen[sp] <= flen[sp] + bl;
            state <= S_OUT;
          end else if (right_m) begin
            fstart[si] <= bs;
            flen[si] <= flen[si] + bl;
            state <= S_OUT;
          end else if (fcount < FIW'(FS)) begin
            i <= fcount;
            state <= S_FINS;
          end else state <= S_OUT;
        end
        S_FINS: begin
          // open a gap from the top down
          if (i > sel) begin
            fstart[ic[$clog2(FS)-1:0]] <= fstart[$clog2(FS)'(ic - 1'b1)];
            flen[ic[$clog2(FS)-1:0]] <= flen[$clog2(FS)'(ic - 1'b1)];
            i <= i - 1'b1;
          end else begin
            fstart[si] <= bs;
            flen[si] <= bl;
            fcount <= fcount + 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: if (!m_tvalid || m_tready) begin
          obuf <= {3'd0, 5'(fcount), 5'(ucount), 16'(bl), 16'(bs), status};
          m_tvalid <= 1'b1;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // write data for a shift-down step comes straight from the read
  assert property (@(posedge clk) disable iff (rst)
    fcount <= FIW'(FS)) else $error("free count overflow");
  assert property (@(posedge clk) disable iff (rst)
    ucount <= UCW'(USED_SLOTS)) else $error("used count overflow");
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result lost");
  assert property (@(posedge clk) disable iff (rst)
    s_tready |-> state == S_IDLE) else $error("ready while busy");
endmodule
`default_nettype wire
